// ----- rtl/md5_pkg.sv -----
// ----------------------------------------------------------------------------
// md5_pkg
// Types, constants and round helper functions for the MD5 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

    typedef logic [31:0] word_t;
    typedef logic [7:0]  byte_t;
    typedef logic [5:0]  round_t;
    typedef logic [63:0] count_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } md5_state_t;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    localparam word_t INIT_A   = 32'h67452301;
    localparam word_t INIT_B   = 32'hefcdab89;
    localparam word_t INIT_C   = 32'h98badcfe;
    localparam word_t INIT_D   = 32'h10325476;
    localparam byte_t PAD_MARK = 8'h80;

    // length field occupies the last two words of the final block
    localparam logic [5:0] LEN_POS = 6'd56;

    localparam word_t ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [4:0] ROUND_S [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [4:0] round_shift(input round_t r);
        return ROUND_S[{r[5:4], r[1:0]}];
    endfunction

    // message word index per round, all arithmetic mod 16
    function automatic logic [3:0] msg_index(input round_t r);
        logic [3:0] t;
        t = r[3:0];
        unique case (r[5:4])
            2'd0: return t;
            2'd1: return 4'(t * 4'd5 + 4'd1);
            2'd2: return 4'(t * 4'd3 + 4'd5);
            2'd3: return 4'(t * 4'd7);
            default: return t;
        endcase
    endfunction

    function automatic word_t round_f(input round_t r, input word_t b, input word_t c,
                                      input word_t d);
        unique case (r[5:4])
            2'd0: return d ^ (b & (c ^ d));
            2'd1: return c ^ (d & (b ^ c));
            2'd2: return b ^ c ^ d;
            2'd3: return c ^ (b | ~d);
            default: return b ^ c ^ d;
        endcase
    endfunction

    function automatic word_t rotl32(input word_t v, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {v, v} << s;
        return dbl[63:32];
    endfunction

    function automatic word_t bswap32(input word_t v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/md5_stream_if.sv -----
// ----------------------------------------------------------------------------
// md5_stream_if
// Valid/ready channels of the MD5 engine: message input and digest output.
// ----------------------------------------------------------------------------
`default_nettype none

interface md5_in_if;
    import md5_pkg::*;

    logic  valid;
    logic  ready;
    logic  kind;
    byte_t data_byte;

    modport source (output valid, kind, data_byte, input ready);
    modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface md5_out_if;
    import md5_pkg::*;

    logic       valid;
    logic       ready;
    word_t      digest_word;
    logic [1:0] word_index;
    logic       last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

`default_nettype wire

// ----- rtl/md5_hash_engine.sv -----
// ----------------------------------------------------------------------------
// md5_hash_engine
// MD5 engine: byte-serial message intake, one compression round per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one message byte (kind = byte) or a finish request per
//   transaction. Bytes pack little-endian into a 64-byte block register.
//   The 64th byte of a block starts the compression: the rounds on the
//   single round datapath and then the chaining add, during which in_ch.ready
//   is low. A finish pads the block and compresses it, or compresses two
//   blocks when 8 or fewer bytes of the block remain.
//   The digest then leaves on out_ch as four word transactions, index 0
//   first, last_word set on index 3; each word is held in registers while
//   the receiver stalls. After the last word the chaining words, bit
//   count and fill position return to their initial values and in_ch
//   reopens.
//   Reset (rst_n low, asynchronous) loads the initial chaining words and
//   clears the bit count, fill position and sequencer; the block register
//   holds no reset value.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_hash_engine (
    input  wire logic clk,
    input  wire logic rst_n,
    md5_in_if.sink    in_ch,
    md5_out_if.source out_ch
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;

    word_t      chain_reg [4];
    word_t      a_reg, b_reg, c_reg, d_reg;
    word_t      block_reg [16];
    count_t     count_reg;
    logic [5:0] pos_reg;
    round_t     round_reg;
    logic       fin_reg;
    logic       extra_reg;
    logic [1:0] idx_reg;

    logic  in_fire;
    logic  out_fire;
    word_t f_val;
    word_t sum_val;
    word_t b_new;
    word_t sum_a, sum_b, sum_c, sum_d;

    assign in_fire  = in_ch.valid & in_ch.ready;
    assign out_fire = out_ch.valid & out_ch.ready;

    // round datapath
    assign f_val   = round_f(round_reg, b_reg, c_reg, d_reg);
    assign sum_val = a_reg + f_val + ROUND_K[round_reg] + block_reg[msg_index(round_reg)];
    assign b_new   = b_reg + rotl32(sum_val, round_shift(round_reg));

    assign sum_a = chain_reg[0] + a_reg;
    assign sum_b = chain_reg[1] + b_reg;
    assign sum_c = chain_reg[2] + c_reg;
    assign sum_d = chain_reg[3] + d_reg;

    always_comb
    begin
        state_next         = state_reg;
        in_ch.ready        = 1'b0;
        out_ch.valid       = 1'b0;
        out_ch.digest_word = bswap32(chain_reg[idx_reg]);
        out_ch.word_index  = idx_reg;
        out_ch.last_word   = (idx_reg == 2'd3);
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ch.ready = 1'b1;
                if (in_fire)
                begin
                    if (in_ch.kind == KIND_FINISH || pos_reg == 6'd63)
                    begin
                        state_next = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                priority if (fin_reg && extra_reg)
                begin
                    state_next = ST_ROUND;
                end
                else if (fin_reg)
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                out_ch.valid = 1'b1;
                if (out_fire && idx_reg == 2'd3)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control and chaining state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= INIT_A;
            chain_reg[1] <= INIT_B;
            chain_reg[2] <= INIT_C;
            chain_reg[3] <= INIT_D;
            a_reg        <= INIT_A;
            b_reg        <= INIT_B;
            c_reg        <= INIT_C;
            d_reg        <= INIT_D;
            count_reg    <= '0;
            pos_reg      <= '0;
            round_reg    <= '0;
            fin_reg      <= 1'b0;
            extra_reg    <= 1'b0;
            idx_reg      <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (in_ch.kind == KIND_BYTE)
                        begin
                            count_reg <= count_reg + 64'd8;
                            pos_reg   <= pos_reg + 6'd1;
                        end
                        else
                        begin
                            fin_reg   <= 1'b1;
                            extra_reg <= (pos_reg >= LEN_POS);
                        end
                        round_reg <= '0;
                    end
                end
                ST_ROUND:
                begin
                    a_reg     <= d_reg;
                    b_reg     <= b_new;
                    c_reg     <= b_reg;
                    d_reg     <= c_reg;
                    round_reg <= round_reg + 6'd1;
                end
                ST_ADD:
                begin
                    // working words track the chaining words between blocks
                    chain_reg[0] <= sum_a;
                    chain_reg[1] <= sum_b;
                    chain_reg[2] <= sum_c;
                    chain_reg[3] <= sum_d;
                    a_reg        <= sum_a;
                    b_reg        <= sum_b;
                    c_reg        <= sum_c;
                    d_reg        <= sum_d;
                    extra_reg    <= 1'b0;
                    round_reg    <= '0;
                    idx_reg      <= '0;
                end
                ST_OUT:
                begin
                    if (out_fire)
                    begin
                        idx_reg <= idx_reg + 2'd1;
                        if (idx_reg == 2'd3)
                        begin
                            chain_reg[0] <= INIT_A;
                            chain_reg[1] <= INIT_B;
                            chain_reg[2] <= INIT_C;
                            chain_reg[3] <= INIT_D;
                            a_reg        <= INIT_A;
                            b_reg        <= INIT_B;
                            c_reg        <= INIT_C;
                            d_reg        <= INIT_D;
                            count_reg    <= '0;
                            pos_reg      <= '0;
                            fin_reg      <= 1'b0;
                        end
                    end
                end
                default:
                begin
                    fin_reg <= 1'b0;
                end
            endcase
        end
    end

    // message block: byte writes, padding and length words
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire)
        begin
            if (in_ch.kind == KIND_BYTE)
            begin
                block_reg[pos_reg[5:2]][{pos_reg[1:0], 3'b000} +: 8] <= in_ch.data_byte;
            end
            else
            begin
                for (int w = 0; w < 16; w++)
                begin
                    for (int l = 0; l < 4; l++)
                    begin
                        if (6'(w * 4 + l) == pos_reg)
                        begin
                            block_reg[w][l*8 +: 8] <= PAD_MARK;
                        end
                        else if (6'(w * 4 + l) > pos_reg)
                        begin
                            block_reg[w][l*8 +: 8] <= '0;
                        end
                    end
                end
                if (pos_reg < LEN_POS)
                begin
                    block_reg[14] <= count_reg[31:0];
                    block_reg[15] <= count_reg[63:32];
                end
            end
        end
        else if (state_reg == ST_ADD && fin_reg && extra_reg)
        begin
            for (int w = 0; w < 14; w++)
            begin
                block_reg[w] <= '0;
            end
            block_reg[14] <= count_reg[31:0];
            block_reg[15] <= count_reg[63:32];
        end
    end

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input open while digest pending");

    a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND && round_reg == 6'd63) |=> (state_reg == ST_ADD))
        else $error("round sequence did not end in chaining add");

    a_finish_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.kind == KIND_FINISH) |=>
            (fin_reg && state_reg == ST_ROUND && round_reg == 6'd0))
        else $error("finish did not start compression");

    a_byte_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && in_ch.kind == KIND_BYTE && pos_reg == 6'd63) |=>
            (state_reg == ST_ROUND && pos_reg == 6'd0))
        else $error("full block did not start compression");

    a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && out_ch.last_word) |=>
            (state_reg == ST_IDLE && count_reg == '0 && pos_reg == '0 && !fin_reg))
        else $error("engine not returned to initial state after digest");

endmodule

`default_nettype wire
